FILE: rtl/cau_pkg.sv
// Package for the complex arithmetic unit: widths, function codes, pipeline item types
// and the saturation helpers shared by the front end and the back end.
// It depends on nothing else.
package cau_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int EXT_W       = DATA_WIDTH + 1;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int SUM_W       = PROD_W + 2;
  localparam int DIV_W       = 3 * DATA_WIDTH;
  localparam int QUO_W       = DATA_WIDTH + 1;
  localparam int N_CELLS     = QUO_W;
  localparam int FUNC_W      = 3;
  localparam int FLAG_W      = 3;
  localparam int IN_TDATA_W  = ((4 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

  localparam int FLAG_CMP = 0;
  localparam int FLAG_OVF = 1;
  localparam int FLAG_DZ  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD     = 3'd0,
    FUNC_SUB     = 3'd1,
    FUNC_MUL     = 3'd2,
    FUNC_DIV     = 3'd3,
    FUNC_GREATER = 3'd4,
    FUNC_LESS    = 3'd5
  } func_e;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    word_t res_real;
    word_t res_imag;
    logic  cmp;
    logic  ovf;
    logic  dz;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic [FUNC_W-1:0] func;
    logic              dz;
    logic              neg_r;
    logic              neg_i;
    logic [DIV_W-1:0]  rem_r;
    logic [DIV_W-1:0]  rem_i;
    logic [DIV_W-1:0]  dvs;
    logic [QUO_W-1:0]  quo_r;
    logic [QUO_W-1:0]  quo_i;
    word_t             res_real;
    word_t             res_imag;
    logic              cmp;
    logic              ovf;
  } div_item_t;

  function automatic logic [DIV_W-1:0] mag_of(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0] a;
    a = x[SUM_W-1] ? -x : x;
    return DIV_W'(a);
  endfunction

  function automatic sat_t saturate(input logic neg, input logic [DIV_W-1:0] mag);
    logic [DIV_W-1:0] lim;
    sat_t r;
    lim = {{(DIV_W-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        r.ovf = 1'b1;
        r.val = lim[DATA_WIDTH-1:0];
      end else begin
        r.val = ~mag[DATA_WIDTH-1:0] + 1'b1;
      end
    end else begin
      if (mag >= lim) begin
        r.ovf = 1'b1;
        r.val = ~lim[DATA_WIDTH-1:0];
      end else begin
        r.val = mag[DATA_WIDTH-1:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed Q8.8 operands.
// The slave channel takes one transfer per item: tdata holds a_real, a_imag, b_real and
// b_imag, tuser holds the function code (add, subtract, multiply, divide, modulus
// greater, modulus less). The master channel gives one transfer per item: tdata holds
// res_real and res_imag, tuser holds compare_true, overflow and divide_by_zero.
// Every item runs through the same pipeline: one stage of multipliers, one stage of
// sums and saturation, a chain of seventeen divider cells that produce one quotient bit
// each, and the output register, which drives m_axis_tvalid.
// Results leave in the order in which the items came in.
// Throughput is one item per cycle when not stalled; the divider chain keeps every item
// in flight. When the receiver stalls, one more result is caught in a spare register
// and the whole pipeline then holds, with s_axis_tready low until the spare empties.
// Reset clears the pipeline and the output buffer; no item is in flight after it.
// Depends on cau_pkg, cau_front, cau_div_cell and cau_back.
module complex_arithmetic_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [cau_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [cau_pkg::FUNC_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // res_real, res_imag
  output logic [cau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // compare_true, overflow, divide_by_zero
  output logic [cau_pkg::FLAG_W-1:0]      m_axis_tuser
);
  import cau_pkg::*;

  logic      en;
  res_t      res;
  div_item_t chain [N_CELLS+1];

  cau_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .func_i   (s_axis_tuser),
    .a_real_i (s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH]),
    .a_imag_i (s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]),
    .b_real_i (s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]),
    .b_imag_i (s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]),
    .item_o   (chain[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  cau_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (chain[N_CELLS]),
    .en_o    (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign s_axis_tready          = en;
  assign m_axis_tdata           = OUT_TDATA_W'({res.res_imag, res.res_real});
  assign m_axis_tuser[FLAG_CMP] = res.cmp;
  assign m_axis_tuser[FLAG_OVF] = res.ovf;
  assign m_axis_tuser[FLAG_DZ]  = res.dz;

endmodule

FILE: rtl/cau_front.sv
// Front end of the complex arithmetic unit: operand products, sums and the finished
// results of every function but division, then the set-up of the divider chain.
// It depends on cau_pkg.
module cau_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [cau_pkg::FUNC_W-1:0] func_i,
  input  cau_pkg::word_t     a_real_i,
  input  cau_pkg::word_t     a_imag_i,
  input  cau_pkg::word_t     b_real_i,
  input  cau_pkg::word_t     b_imag_i,
  output cau_pkg::div_item_t item_o
);
  import cau_pkg::*;

  logic                     valid_q;
  logic [FUNC_W-1:0]        func_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PROD_W-1:0] s_ar_q, s_ai_q, s_br_q, s_bi_q;
  logic signed [EXT_W-1:0]  add_r_q, add_i_q, sub_r_q, sub_i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      func_q  <= func_i;
      p_rr_q  <= PROD_W'(a_real_i) * PROD_W'(b_real_i);
      p_ii_q  <= PROD_W'(a_imag_i) * PROD_W'(b_imag_i);
      p_ri_q  <= PROD_W'(a_real_i) * PROD_W'(b_imag_i);
      p_ir_q  <= PROD_W'(a_imag_i) * PROD_W'(b_real_i);
      s_ar_q  <= PROD_W'(a_real_i) * PROD_W'(a_real_i);
      s_ai_q  <= PROD_W'(a_imag_i) * PROD_W'(a_imag_i);
      s_br_q  <= PROD_W'(b_real_i) * PROD_W'(b_real_i);
      s_bi_q  <= PROD_W'(b_imag_i) * PROD_W'(b_imag_i);
      add_r_q <= EXT_W'(a_real_i) + EXT_W'(b_real_i);
      add_i_q <= EXT_W'(a_imag_i) + EXT_W'(b_imag_i);
      sub_r_q <= EXT_W'(a_real_i) - EXT_W'(b_real_i);
      sub_i_q <= EXT_W'(a_imag_i) - EXT_W'(b_imag_i);
    end
  end

  logic signed [SUM_W-1:0] mul_re, mul_im, div_re, div_im, mag_a, mag_b;
  sat_t                    sat_r, sat_i;
  div_item_t               item_d;
  div_item_t               item_q;

  assign mul_re = SUM_W'(p_rr_q) - SUM_W'(p_ii_q);
  assign mul_im = SUM_W'(p_ri_q) + SUM_W'(p_ir_q);
  assign div_re = SUM_W'(p_rr_q) + SUM_W'(p_ii_q);
  assign div_im = SUM_W'(p_ir_q) - SUM_W'(p_ri_q);
  assign mag_a  = SUM_W'(s_ar_q) + SUM_W'(s_ai_q);
  assign mag_b  = SUM_W'(s_br_q) + SUM_W'(s_bi_q);

  always_comb begin
    sat_r = '0;
    sat_i = '0;
    item_d = '0;
    item_d.valid = valid_q;
    item_d.func  = func_q;
    item_d.dvs   = DIV_W'(mag_b) << DATA_WIDTH;
    unique case (func_q)
      FUNC_ADD: begin
        sat_r = saturate(add_r_q[EXT_W-1], mag_of(SUM_W'(add_r_q)));
        sat_i = saturate(add_i_q[EXT_W-1], mag_of(SUM_W'(add_i_q)));
      end
      FUNC_SUB: begin
        sat_r = saturate(sub_r_q[EXT_W-1], mag_of(SUM_W'(sub_r_q)));
        sat_i = saturate(sub_i_q[EXT_W-1], mag_of(SUM_W'(sub_i_q)));
      end
      FUNC_MUL: begin
        sat_r = saturate(mul_re[SUM_W-1], mag_of(mul_re) >> FRAC_BITS);
        sat_i = saturate(mul_im[SUM_W-1], mag_of(mul_im) >> FRAC_BITS);
      end
      FUNC_DIV: begin
        item_d.dz    = (mag_b == '0);
        item_d.neg_r = div_re[SUM_W-1];
        item_d.neg_i = div_im[SUM_W-1];
        item_d.rem_r = mag_of(div_re) << FRAC_BITS;
        item_d.rem_i = mag_of(div_im) << FRAC_BITS;
      end
      FUNC_GREATER: item_d.cmp = (mag_a > mag_b);
      FUNC_LESS:    item_d.cmp = (mag_a < mag_b);
      default: ;
    endcase
    item_d.res_real = sat_r.val;
    item_d.res_imag = sat_i.val;
    item_d.ovf      = sat_r.ovf | sat_i.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/cau_div_cell.sv
// One cell of the divider chain: a restoring step for the real and imaginary quotients
// against a shared divisor, which it halves on its way to the next cell.
// It depends on cau_pkg.
module cau_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cau_pkg::div_item_t item_i,
  output cau_pkg::div_item_t item_o
);
  import cau_pkg::*;

  logic      ge_r, ge_i;
  div_item_t item_d;
  div_item_t item_q;

  assign ge_r = (item_i.rem_r >= item_i.dvs);
  assign ge_i = (item_i.rem_i >= item_i.dvs);

  always_comb begin
    item_d       = item_i;
    item_d.rem_r = ge_r ? item_i.rem_r - item_i.dvs : item_i.rem_r;
    item_d.rem_i = ge_i ? item_i.rem_i - item_i.dvs : item_i.rem_i;
    item_d.quo_r = {item_i.quo_r[QUO_W-2:0], ge_r};
    item_d.quo_i = {item_i.quo_i[QUO_W-2:0], ge_i};
    item_d.dvs   = item_i.dvs >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/cau_back.sv
// Back end of the complex arithmetic unit: saturation of the quotients, selection of
// the result and a two-entry output buffer that decouples the pipeline from the sink.
// It depends on cau_pkg.
module cau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cau_pkg::div_item_t item_i,
  output logic               en_o,
  output logic               valid_o,
  input  logic               ready_i,
  output cau_pkg::res_t      res_o
);
  import cau_pkg::*;

  sat_t sat_r, sat_i;
  res_t res_d;
  res_t out_q, spare_q;
  logic out_valid_q, spare_valid_q;
  logic incoming;
  logic out_free;

  always_comb begin
    sat_r = saturate(item_i.neg_r, DIV_W'(item_i.quo_r));
    sat_i = saturate(item_i.neg_i, DIV_W'(item_i.quo_i));
    res_d.cmp = item_i.cmp;
    res_d.dz  = item_i.dz;
    if (item_i.func == FUNC_DIV && !item_i.dz) begin
      res_d.res_real = sat_r.val;
      res_d.res_imag = sat_i.val;
      res_d.ovf      = sat_r.ovf | sat_i.ovf;
    end else begin
      res_d.res_real = item_i.res_real;
      res_d.res_imag = item_i.res_imag;
      res_d.ovf      = item_i.ovf;
    end
  end

  assign en_o     = !spare_valid_q;
  assign incoming = en_o && item_i.valid;
  assign out_free = ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q   <= spare_valid_q || incoming;
      spare_valid_q <= 1'b0;
    end else if (incoming) begin
      spare_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= spare_valid_q ? spare_q : res_d;
    end else if (incoming) begin
      spare_q <= res_d;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

FILE: rtl/cau_checker.sv
// Checker for the complex arithmetic unit ports, bound to the top level.
// It depends on cau_pkg and on complex_arithmetic_unit.
module cau_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [cau_pkg::FLAG_W-1:0]      m_axis_tuser
);
  import cau_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Output transfer changed while stalled.");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("Input held off while no result is waiting.");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[FLAG_DZ] |->
      m_axis_tdata == '0 && !m_axis_tuser[FLAG_OVF] && !m_axis_tuser[FLAG_CMP])
    else $error("Division by zero gave a non-zero result.");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[FLAG_CMP] |->
      m_axis_tdata == '0 && !m_axis_tuser[FLAG_OVF])
    else $error("Comparison gave arithmetic output.");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
